// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CELL_W = 16;
  typedef logic [CELL_W-1:0] cell_t;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PUT   = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;
  localparam cmd_t CMD_CLEAR = 2'd3;

  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam int TAB_STEP = 4;
  localparam logic [7:0] COLOR_RESET = 8'h0F;

endpackage

// ===== src/tcce_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_cell_ram
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcce_cell_ram
  import tcce_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character-cell text screen with cell memory, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one command beat. s_tuser[1:0] = cmd, s_tdata = char_code,
//   cell_color, col, row (8 bits each, char_code lowest).
//   m_* channel: one result beat per command, cursor state after it, read
//   data, and the scrolled / ignored flags in m_tuser.
//   cfg_we / cfg_wdata: writes the text color; write it only while idle.
// Timing:
//   put, write and read cell: the command passes the execute and done states;
//   m_tvalid rises as it leaves done and s_tready returns with it. A put
//   that scrolls then copies one cell per cycle through the memory read and write
//   ports, then fills the bottom row. Clear writes one cell per cycle through
//   the write port.
//   s_tready is high only while the sequencer is idle; one command at a time.
// Reset: cursor at 0,0, text color 0x0F, no result pending. Cell memory is
//   undefined until the first clear.
// Stall: a finished result sits in the output register until m_tready; the
//   sequencer waits for the register before reporting the next one.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code, cell_color, col, row
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // cursor_col, cursor_row, cursor_pos, cell_data, pad
  output logic [1:0]  m_tuser,   // scrolled, ignored
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int AW     = $clog2(CELLS);
  localparam int PW     = (AW > 11) ? AW : 11;
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  cmd_t          cmd_q;
  logic [7:0]    ch_q, attr_q, col_q, row_q;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [7:0]    text_color;
  logic [AW-1:0] idx;
  logic          scroll_flag, ign_flag, read_hit;

  logic          out_valid;
  logic [6:0]    o_col;
  logic [4:0]    o_row;
  logic [10:0]   o_pos;
  cell_t         o_data;
  logic          o_scrolled, o_ignored;

  // shared address unit
  logic [RW-1:0] add_row;
  logic [PW-1:0] add_b, row_term, add_sum;

  logic [CW:0]   ncol;
  logic [RW:0]   nrow;
  logic          put_we, need_scroll;
  logic [7:0]    put_char;
  logic [CW-1:0] put_wcol;
  logic          in_range;
  cell_t         blank;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t         ram_wdata, rd_data;

  assign blank    = {text_color, BLANK_CHAR};
  assign in_range = (col_q < 8'(COLUMNS)) && (row_q < 8'(ROWS));
  assign put_wcol = (ch_q == CH_BS) ? cur_col - CW'(1) : cur_col;

  always_comb begin
    add_row = cur_row;
    add_b   = PW'(cur_col);
    if (state == S_EXEC && cmd_q != CMD_PUT) begin
      add_row = row_q[RW-1:0];
      add_b   = PW'(col_q[CW-1:0]);
    end else if (state == S_EXEC) begin
      add_b = PW'(put_wcol);
    end else if (state == S_COPY) begin
      add_b = PW'(idx);
    end
    row_term = PW'(add_row) * PW'(COLUMNS);
    add_sum  = ((state == S_COPY) ? PW'(COLUMNS) : row_term) + add_b;
  end

  // cursor motion of a put character
  always_comb begin
    ncol     = {1'b0, cur_col};
    nrow     = {1'b0, cur_row};
    put_we   = 1'b0;
    put_char = ch_q;
    unique case (ch_q)
      CH_LF: begin
        ncol = '0;
        nrow = nrow + (RW+1)'(1);
      end
      CH_CR: begin
        ncol = '0;
      end
      CH_TAB: begin
        ncol = ({1'b0, cur_col} + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));
      end
      CH_BS: begin
        if (cur_col != '0) begin
          ncol     = {1'b0, cur_col} - (CW+1)'(1);
          put_we   = 1'b1;
          put_char = BLANK_CHAR;
        end
      end
      default: begin
        put_we = 1'b1;
        ncol   = {1'b0, cur_col} + (CW+1)'(1);
      end
    endcase
    if (ncol >= (CW+1)'(COLUMNS)) begin
      ncol = '0;
      nrow = nrow + (RW+1)'(1);
    end
    need_scroll = (nrow >= (RW+1)'(ROWS));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = add_sum[AW-1:0];
    ram_raddr = add_sum[AW-1:0];
    ram_wdata = blank;
    unique case (state)
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUT: begin
            ram_we    = put_we;
            ram_wdata = {text_color, put_char};
          end
          CMD_WRITE: begin
            ram_we    = in_range;
            ram_wdata = {attr_q, ch_q};
          end
          CMD_READ:  ram_re = in_range;
          default:   ram_we = 1'b0;
        endcase
      end
      S_CLEAR, S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
      end
      S_COPY: begin
        // read one row down, write the cell read last cycle one slot back
        ram_re    = (idx != AW'(COPY_N));
        ram_we    = (idx != '0);
        ram_waddr = idx - AW'(1);
        ram_wdata = rd_data;
      end
      default: ram_we = 1'b0;
    endcase
  end

  tcce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_col    <= '0;
      cur_row    <= '0;
      text_color <= COLOR_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tuser;
            ch_q   <= s_tdata[7:0];
            attr_q <= s_tdata[15:8];
            col_q  <= s_tdata[23:16];
            row_q  <= s_tdata[31:24];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          scroll_flag <= (cmd_q == CMD_PUT) && need_scroll;
          ign_flag    <= ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)) && !in_range;
          read_hit    <= (cmd_q == CMD_READ) && in_range;
          unique case (cmd_q)
            CMD_PUT: begin
              cur_col <= ncol[CW-1:0];
              if (need_scroll) begin
                cur_row <= RW'(ROWS - 1);
                idx     <= '0;
                state   <= S_COPY;
              end else begin
                cur_row <= nrow[RW-1:0];
                state   <= S_DONE;
              end
            end
            CMD_WRITE: begin
              state <= S_DONE;
            end
            CMD_READ: begin
              state <= S_DONE;
            end
            default: begin
              cur_col <= '0;
              cur_row <= '0;
              idx     <= '0;
              state   <= S_CLEAR;
            end
          endcase
        end
        S_CLEAR, S_FILL: begin
          if (idx == AW'(CELLS - 1)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_COPY: begin
          if (idx == AW'(COPY_N)) begin
            state <= S_FILL;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            o_col      <= 7'(cur_col);
            o_row      <= 5'(cur_row);
            o_pos      <= add_sum[10:0];
            o_data     <= read_hit ? rd_data : '0;
            o_scrolled <= scroll_flag;
            o_ignored  <= ign_flag;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, o_data, o_pos, o_row, o_col};
  assign m_tuser  = {o_ignored, o_scrolled};

`ifndef NO_ASSERTIONS
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < (CW+1)'(COLUMNS)) && ({1'b0, cur_row} < (RW+1)'(ROWS)))
    else $error("cursor outside the screen");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE))
    else $error("cell write while idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted beat not executed");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(o_scrolled && o_ignored))
    else $error("scrolled and ignored both set");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor engine: a cursor and cell
// model in the bench predicts every result beat; directed tests cover cell
// access, clear and the control characters, then random traffic runs over
// several text colors with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int TOTAL_ITEMS = 1550;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 64'd4 * (TOTAL_ITEMS + 100) * (2 * CELLS + 200);

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic [15:0] data;
    logic        scrolled;
    logic        ignored;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // screen and cursor as the bench expects them
  logic [15:0] screen_model [CELLS];
  bit          cell_known [CELLS];
  int          cursor_col_m;
  int          cursor_row_m;
  logic [7:0]  text_color_m;

  cursor_report_t cursor_reports_q[$];

  bit     steady = 1'b0;
  int     mismatch_count = 0;
  int     item_count = 0;
  int     checked_count = 0;
  int     put_count = 0;
  int     scroll_count = 0;
  int     clear_count = 0;
  int     read_count = 0;
  int     ignored_count = 0;
  int     color_count = 0;
  longint cycle_count = 0;

  text_console_cursor_engine #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // char_code, cell_color, col, row
    .s_tuser(s_tuser),     // cmd
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // cursor_col, cursor_row, cursor_pos, cell_data, pad
    .m_tuser(m_tuser),     // scrolled, ignored
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               cursor_reports_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 38);
  end

  // applies one command to the bench screen and returns the cursor report
  function automatic cursor_report_t console_apply(cmd_t cmd, logic [7:0] ch,
                                                   logic [7:0] attr, logic [7:0] c,
                                                   logic [7:0] r);
    cursor_report_t rep;
    bit in_range;
    int idx;
    rep = '0;
    in_range = (c < COLUMNS) && (r < ROWS);
    idx = int'(r) * COLUMNS + int'(c);
    case (cmd)
      CMD_PUT: begin
        put_count++;
        case (ch)
          CH_LF: begin
            cursor_col_m = 0;
            cursor_row_m++;
          end
          CH_CR: cursor_col_m = 0;
          CH_TAB: cursor_col_m = (cursor_col_m + TAB_STEP) & ~(TAB_STEP - 1);
          CH_BS: begin
            if (cursor_col_m > 0) begin
              cursor_col_m--;
              screen_model[cursor_row_m * COLUMNS + cursor_col_m] = {text_color_m, BLANK_CHAR};
              cell_known[cursor_row_m * COLUMNS + cursor_col_m] = 1'b1;
            end
          end
          default: begin
            screen_model[cursor_row_m * COLUMNS + cursor_col_m] = {text_color_m, ch};
            cell_known[cursor_row_m * COLUMNS + cursor_col_m] = 1'b1;
            cursor_col_m++;
          end
        endcase
        if (cursor_col_m >= COLUMNS) begin
          cursor_col_m = 0;
          cursor_row_m++;
        end
        if (cursor_row_m >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
            cell_known[i] = cell_known[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_model[i] = {text_color_m, BLANK_CHAR};
            cell_known[i] = 1'b1;
          end
          cursor_row_m = ROWS - 1;
          rep.scrolled = 1'b1;
          scroll_count++;
        end
      end
      CMD_WRITE: begin
        if (in_range) begin
          screen_model[idx] = {attr, ch};
          cell_known[idx] = 1'b1;
        end else begin
          rep.ignored = 1'b1;
        end
      end
      CMD_READ: begin
        read_count++;
        if (in_range) rep.data = screen_model[idx];
        else rep.ignored = 1'b1;
      end
      default: begin
        clear_count++;
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = {text_color_m, BLANK_CHAR};
          cell_known[i] = 1'b1;
        end
        cursor_col_m = 0;
        cursor_row_m = 0;
      end
    endcase
    if (rep.ignored) ignored_count++;
    rep.col = cursor_col_m[6:0];
    rep.row = cursor_row_m[4:0];
    rep.pos = 11'(cursor_row_m * COLUMNS + cursor_col_m);
    return rep;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 checked_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cursor_reports_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing expected: tdata 0x%0h tuser 0x%0h",
                   m_tdata, m_tuser);
      end else begin
        want = cursor_reports_q.pop_front();
        compare_field("cursor_col", 32'(want.col), 32'(m_tdata[6:0]));
        compare_field("cursor_row", 32'(want.row), 32'(m_tdata[11:7]));
        compare_field("cursor_pos", 32'(want.pos), 32'(m_tdata[22:12]));
        compare_field("cell_data", 32'(want.data), 32'(m_tdata[38:23]));
        compare_field("scrolled", 32'(want.scrolled), 32'(m_tuser[0]));
        compare_field("ignored", 32'(want.ignored), 32'(m_tuser[1]));
        checked_count++;
      end
    end
  end

  // one command beat; reads of never-written cells are steered out of range
  task automatic send_cmd(input cmd_t cmd, input logic [7:0] ch, input logic [7:0] attr,
                          input logic [7:0] c, input logic [7:0] r);
    if (cmd == CMD_READ && c < COLUMNS && r < ROWS && !cell_known[int'(r) * COLUMNS + int'(c)])
      r = 8'(ROWS);
    while (!steady && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {r, c, attr, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cursor_reports_q.push_back(console_apply(cmd, ch, attr, c, r));
    item_count++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_cmd(CMD_PUT, ch, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (cursor_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_color(input logic [7:0] color);
    cfg_we <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_color_m = color;
    color_count++;
  endtask

  task automatic test_cell_access();
    send_cmd(CMD_WRITE, 8'hFF, 8'hAB, 8'd0, 8'd0);
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'd0, 8'd0);
    send_cmd(CMD_WRITE, 8'h00, 8'h54, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send_cmd(CMD_READ, 8'hFF, 8'hFF, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send_cmd(CMD_WRITE, 8'h41, 8'h12, 8'(COLUMNS), 8'd0);
    send_cmd(CMD_WRITE, 8'h41, 8'h12, 8'd0, 8'(ROWS));
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'hFF, 8'hFF);
  endtask

  task automatic test_clear_screen();
    // cleared with the reset color
    send_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'd40, 8'd12);
  endtask

  task automatic test_put_characters();
    send_put(8'h41);
    send_put(8'h00);
    send_put(8'h80);
    send_put(8'hFF);
    send_put(CH_TAB);
    send_put(CH_TAB);
    send_put(CH_BS);
    send_put(CH_CR);
    send_put(CH_BS);    // at column 0 nothing moves
    send_put(CH_LF);
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'd1, 8'd0);
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'd3, 8'd0);
    send_cmd(CMD_READ, 8'h00, 8'h00, 8'd7, 8'd0);
  endtask

  task automatic run_random_traffic(input int count);
    int target;
    int sel;
    int len;
    bit is_read;
    logic [7:0] c;
    logic [7:0] r;
    target = item_count + count;
    while (item_count < target) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = $urandom_range(90, 1);
        repeat (len) begin
          sel = $urandom_range(99);
          if (sel < 70) send_put(8'($urandom_range(126, 32)));
          else if (sel < 85) send_put(8'($urandom_range(255)));
          else if (sel < 90) send_put(CH_TAB);
          else if (sel < 95) send_put(CH_BS);
          else send_put(CH_CR);
        end
        if ($urandom_range(1)) send_put(CH_LF);
      end else if (sel < 53) begin
        repeat ($urandom_range(12, 1)) send_put(CH_LF);
      end else if (sel < 60) begin
        repeat ($urandom_range(25, 1)) send_put(CH_TAB);
      end else if (sel < 68) begin
        repeat ($urandom_range(10, 1)) send_put(CH_BS);
      end else if (sel < 93) begin
        repeat ($urandom_range(8, 1)) begin
          is_read = $urandom_range(1);
          if ($urandom_range(99) < 85) begin
            c = 8'($urandom_range(COLUMNS - 1));
            r = 8'($urandom_range(ROWS - 1));
          end else begin
            c = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
          end
          send_cmd(is_read ? CMD_READ : CMD_WRITE, 8'($urandom_range(255)),
                   8'($urandom_range(255)), c, r);
        end
      end else if (sel < 97) begin
        send_cmd(cmd_t'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        send_cmd(CMD_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_color_phases();
    logic [7:0] color;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // every result is back before the color changes
      wait_results_drained();
      case (phase)
        0: color = 8'h00;
        1: color = 8'hFF;
        default: color = 8'($urandom_range(255));
      endcase
      write_text_color(color);
      steady = (phase == 2);
      run_random_traffic(TOTAL_ITEMS / NUM_PHASES);
      steady = 1'b0;
    end
  endtask

  initial begin
    text_color_m = COLOR_RESET;
    cursor_col_m = 0;
    cursor_row_m = 0;
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = '0;
      cell_known[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cell_access();
    test_clear_screen();
    test_put_characters();
    test_color_phases();

    wait_results_drained();
    if (cursor_reports_q.size() != 0) begin
      mismatch_count += cursor_reports_q.size();
      $display("%0d expected results never arrived", cursor_reports_q.size());
    end
    $display("covered %0d commands: %0d puts with %0d scrolls, %0d reads, %0d ignored addresses",
             item_count, put_count, scroll_count, read_count, ignored_count);
    $display("%0d clears over %0d text colors, %0d results checked, %0d mismatches",
             clear_count, color_count + 1, checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tcce_pkg.sv
src/tcce_cell_ram.sv
src/text_console_cursor_engine.sv
tb/tb_top.sv
